FILE: rtl/jsu_pkg.sv
// jsu_pkg: shared types, character codes and utf-8 helpers for the json unescaper
// used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8_top
`timescale 1ns / 1ps

package jsu_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_UPF    = 8'h46;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_UPA    = 8'h41;
  localparam logic [7:0] CH_LOWA   = 8'h61;

  // surrogate and code point limits
  localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
  localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
  localparam logic [31:0] SUPP_BASE      = 32'h0001_0000;
  localparam logic [31:0] CP_MAX         = 32'h0010_FFFF;

  // channel payloads
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // one queued job: a raw byte or a code point to encode
  typedef struct packed {
    logic        raw;
    logic [20:0] cp;
  } job_t;

  // front to queue
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // queue head to back
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  // value of a hex digit, non-hex bytes included, mod 16
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    if (c <= CH_DIG9) begin
      d = c - CH_DIG0;
    end else if (c <= CH_UPF) begin
      d = c - CH_UPA + 8'd10;
    end else begin
      d = c - CH_LOWA + 8'd10;
    end
    return d[3:0];
  endfunction

  // single-byte escape letters, anything unknown maps to '?'
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] b;
    unique case (c)
      CH_QUOTE:  b = CH_QUOTE;
      CH_BSLASH: b = CH_BSLASH;
      CH_B:      b = CH_BS;
      CH_F:      b = CH_FF;
      CH_N:      b = CH_LF;
      CH_R:      b = CH_CR;
      CH_T:      b = CH_TAB;
      CH_V:      b = CH_VT;
      default:   b = CH_QMARK;
    endcase
    return b;
  endfunction

  // number of output bytes minus one
  function automatic logic [1:0] utf8_len_m1(input job_t j);
    logic [1:0] n;
    if (j.raw || (j.cp[20:7] == '0)) begin
      n = 2'd0;
    end else if (j.cp[20:11] == '0) begin
      n = 2'd1;
    end else if (j.cp[20:16] == '0) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // byte idx of the encoding of cp
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = cp[7:0];
    case (len_m1)
      2'd1: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd3: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/jsu_front.sv
// jsu_front: escape state machine, hex accumulation and surrogate combining
// depends on jsu_pkg; pushes one job per byte-producing input into jsu_queue
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output push_t    push_o
);

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_ESC   = 6'b000010,
    PH_HEX   = 6'b000100,
    PH_SKIP1 = 6'b001000,
    PH_SKIP2 = 6'b010000,
    PH_LOW   = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  dig_q, dig_d;
  logic [15:0] accum_q, accum_d;
  logic [15:0] high_q, high_d;
  logic [15:0] hex_next;
  logic [31:0] hi_w, lo_w, cp_w;
  logic [7:0]  c;

  assign c        = item_i.in_byte;
  assign hex_next = {accum_q[11:0], hex_value(c)};

  // surrogate pair combining in 32-bit wraparound arithmetic
  assign hi_w = (32'(high_q) - 32'(SURR_HIGH_BASE)) << 10;
  assign lo_w = 32'(hex_next) - 32'(SURR_LOW_BASE);
  assign cp_w = (hi_w | lo_w) + SUPP_BASE;

  // next state and job push
  always_comb begin
    phase_d          = phase_q;
    dig_d            = dig_q;
    accum_d          = accum_q;
    high_d           = high_q;
    push_o.valid     = 1'b0;
    push_o.job.raw   = 1'b1;
    push_o.job.cp    = 21'(c);
    if (accept_i) begin
      unique case (phase_q)
        PH_ESC: begin
          phase_d = PH_IDLE;
          if (c == CH_U) begin
            phase_d = PH_HEX;
            dig_d   = 2'd0;
            accum_d = '0;
          end else begin
            push_o.valid  = 1'b1;
            push_o.job.cp = 21'(esc_map(c));
          end
        end
        PH_HEX: begin
          accum_d = hex_next;
          dig_d   = dig_q + 2'd1;
          if (dig_q == 2'd3) begin
            if ((hex_next >= SURR_HIGH_BASE) && (hex_next < SURR_LOW_BASE)) begin
              high_d  = hex_next;
              phase_d = PH_SKIP1;
            end else begin
              push_o.valid   = 1'b1;
              push_o.job.raw = 1'b0;
              push_o.job.cp  = 21'(hex_next);
              phase_d        = PH_IDLE;
            end
          end
        end
        PH_SKIP1: begin
          phase_d = PH_SKIP2;
        end
        PH_SKIP2: begin
          accum_d = '0;
          dig_d   = 2'd0;
          phase_d = PH_LOW;
        end
        PH_LOW: begin
          accum_d = hex_next;
          dig_d   = dig_q + 2'd1;
          if (dig_q == 2'd3) begin
            push_o.valid   = (cp_w <= CP_MAX);
            push_o.job.raw = 1'b0;
            push_o.job.cp  = cp_w[20:0];
            phase_d        = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (c == CH_BSLASH) begin
            phase_d = PH_ESC;
          end else begin
            push_o.valid = 1'b1;
          end
        end
      endcase
      // end of string drops an unfinished escape
      if (item_i.in_last) begin
        phase_d = PH_IDLE;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dig_q   <= 2'd0;
      accum_q <= '0;
      high_q  <= '0;
    end else begin
      phase_q <= phase_d;
      dig_q   <= dig_d;
      accum_q <= accum_d;
      high_q  <= high_d;
    end
  end

endmodule

FILE: rtl/jsu_queue.sv
// jsu_queue: small fifo of jobs between front and back
// depends on jsu_pkg for the job, push and head types
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output head_t head_o,
  output logic  full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o      = (count_q == DepthCnt);
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  // fill count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("queue count above depth");

  // front only pushes when there is room
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i.valid |-> !full_o)
    else $error("push into full queue");

  // count follows transfers in and out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + CntW'($past(do_push)) - CntW'($past(do_pop)))
    else $error("queue count mismatch");

endmodule

FILE: rtl/jsu_back.sv
// jsu_back: turns queued jobs into utf-8 bytes in the output register, one per cycle
// unless the output is stalled; depends on jsu_pkg for job types and encode helpers
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  head_t     head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic       out_valid_q;
  out_item_t  out_q;
  logic [1:0] idx_q;
  logic [1:0] len_m1;
  logic       load;
  logic       at_end;

  assign len_m1 = utf8_len_m1(head_i.job);
  assign load   = !out_valid_q || !out_stall_i;
  assign at_end = (idx_q == len_m1);
  assign pop_o  = load && head_i.valid && at_end;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // output payload
  always_ff @(posedge clk_i) begin
    if (load && head_i.valid) begin
      out_q.out_byte <= utf8_byte(head_i.job.cp, len_m1, idx_q);
      out_q.run_last <= at_end;
    end
  end

  // output valid and byte index within the job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= head_i.valid;
      if (head_i.valid) begin
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  // a job part way through stays at the head
  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q != 2'd0 |-> head_i.valid)
    else $error("byte index without a job");

  // byte index stays inside the job length
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_i.valid |-> idx_q <= len_m1)
    else $error("byte index past job length");

endmodule

FILE: rtl/json_string_unescape_utf8_top.sv
// json_string_unescape_utf8_top: json string body unescaper with utf-8 output
// depends on jsu_pkg, jsu_front, jsu_queue and jsu_back
`timescale 1ns / 1ps

// usage:
//  input channel: one byte of the escaped string body per transfer, with in_last on the
//  final byte; a transfer happens when in_valid_i is high and in_stall_o is low.
//  output channel: unescaped utf-8 bytes, run_last set on the final byte that one input
//  byte produces; a transfer happens when out_valid_o is high and out_stall_i is low.
//  ordering: an input byte's job is written into the queue, and its first output byte
//  is then loaded into the output register. inputs that produce nothing (backslash,
//  hex digits, surrogate gap, code points above 0x10ffff) are consumed without output.
//  throughput: one input byte per cycle while in_stall_o is low; the back end sends
//  one output byte per cycle while out_stall_i is low, so a 2, 3 or 4 byte code point
//  holds it for all its bytes; the job queue (QueueDepth entries) absorbs such bursts.
//  reset: asynchronous, active low; clears the escape state, empties the queue and
//  drops out_valid_o. no clearing pass is needed.
//  stall: while out_stall_i is high the output byte holds; the queue keeps taking
//  input until it is full, then in_stall_o is raised.
module json_string_unescape_utf8_top import jsu_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  push_t push;
  head_t head;
  logic  pop;
  logic  full;
  logic  accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // front: escape decoding
  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_o   (push)
  );

  // job queue
  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  // back: utf-8 byte emission
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
